>>> hw/rtl/rqst_pkg.sv
package rqst_pkg;

    localparam int ENTRIES = 128;
    localparam int QUEUES  = 64;
    localparam int EIW     = $clog2(ENTRIES);
    localparam int QIW     = $clog2(QUEUES);
    localparam int PW      = 6;
    localparam int QEW     = PW + EIW;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic REG_QUEUE_COUNT = 1'b0;
    localparam logic REG_TABLE_LOG2  = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LRD  = 9'b000000010,
        S_LCMP = 9'b000000100,
        S_CRD  = 9'b000001000,
        S_CWR  = 9'b000010000,
        S_TRD  = 9'b000100000,
        S_QRD  = 9'b001000000,
        S_FB   = 9'b010000000,
        S_EVAL = 9'b100000000
    } t_state;

endpackage

>>> hw/rtl/rqst_ram.sv
module rqst_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rss_queue_steering_table_core.sv
// Receive-side-scaling queue steering table.
// Input channel (i_s_*): one transaction carries one command. tuser holds the
// opcode (load entry, commit staged table, look up queue); tdata holds the
// entry, processor, hash and inspection fields. Output channel (o_m_*): one
// result transaction per command, with the status code in tuser.
// Configuration channel (i_cfg_*): register index and data, always ready.
// Only one command is in flight; the input is ready while the sequencer idles
// with no result pending, even when a result still waits in the output register.
// Each command steps through the sequencer states: a hashed lookup reads the
// active table, then the queue RAM, then evaluates; a zero-hash scan repeats
// this for each active entry visited and falls back to queue 0 when none
// matches; a load compares the staged queues in turn until one matches or a
// new one opens; a commit copies all 128 entries, reading then writing each;
// a failed, rejected or unused command gives its result on acceptance. The
// next command is accepted once the result has moved to the output register.
// Each table RAM has one read port. Reset clears the sequencer, table size,
// staging counters and active-table valid flags and sets the queue count to
// 1; no clearing pass is needed. A stalled receiver holds the result
// register; a following result waits in the sequencer.
module rss_queue_steering_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: entry_index[6:0], entry_processor[12:7], flow_hash[44:13],
    // current_processor[50:45], tx_inspect[51], zero fill[55:52]
    input  logic [55:0] i_s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: queue_index[5:0], queue_processor[11:6], queue_first_entry[18:12],
    // queues_assigned[25:19], zero fill[31:26]
    output logic [31:0] o_m_tdata,
    // tuser: status[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int EIW = rqst_pkg::EIW;
    localparam int QIW = rqst_pkg::QIW;
    localparam int PW  = rqst_pkg::PW;
    localparam int QEW = rqst_pkg::QEW;

    rqst_pkg::t_state r_state, n_state;

    logic [6:0]        r_qcount;
    logic [2:0]        r_tsl2;
    logic [EIW-1:0]    r_mask, n_mask;
    logic              r_ainit, n_ainit;
    logic [rqst_pkg::QUEUES-1:0] r_qvalid, n_qvalid;
    logic [QIW:0]      r_assigned, n_assigned;
    logic              r_failed, n_failed;
    logic [EIW-1:0]    r_entry, n_entry;
    logic [PW-1:0]     r_proc, n_proc;
    logic [PW-1:0]     r_cur, n_cur;
    logic              r_scan, n_scan;
    logic [EIW-1:0]    r_addr, n_addr;
    logic [EIW-1:0]    r_cnt, n_cnt;
    logic [QIW-1:0]    r_q, n_q;

    // Pending result and output register.
    logic              r_rdy, n_rdy;
    logic [QIW-1:0]    r_rq, n_rq;
    logic [PW-1:0]     r_rp, n_rp;
    logic [EIW-1:0]    r_rf, n_rf;
    logic [QIW:0]      r_ra, n_ra;
    logic [1:0]        r_rs, n_rs;
    logic              r_ovalid;
    logic [25:0]       r_odata;
    logic [1:0]        r_ostat;

    // RAM ports.
    logic              stab_we, sq_we, atab_we, aq_we;
    logic [QIW-1:0]    stab_wdata;
    logic [QIW-1:0]    stab_rd, atab_rd;
    logic [QEW-1:0]    sq_rd, aq_rd;
    logic [QIW-1:0]    aq_raddr;

    logic              s_accept, out_load;
    logic              eff_failed;
    logic [QIW:0]      eff_assigned;
    logic [31:0]       in_hash;
    logic [QIW-1:0]    tab_q;
    logic [PW-1:0]     ev_proc;
    logic [EIW-1:0]    ev_first;

    assign o_s_tready = (r_state == rqst_pkg::S_IDLE) && !r_rdy;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign in_hash    = i_s_tdata[44:13];
    assign eff_failed   = (i_s_tdata[6:0] == '0) ? 1'b0 : r_failed;
    assign eff_assigned = (i_s_tdata[6:0] == '0) ? '0 : r_assigned;
    assign tab_q      = r_ainit ? atab_rd : '0;
    assign ev_proc    = r_qvalid[r_q] ? aq_rd[PW-1:0] : '0;
    assign ev_first   = r_qvalid[r_q] ? aq_rd[QEW-1:PW] : '0;
    assign out_load   = r_rdy && (!r_ovalid || i_m_tready);

    rqst_ram #(.W(QIW), .D(rqst_pkg::ENTRIES)) u_stab (
        .i_clk(i_clk), .i_we(stab_we), .i_waddr(r_entry), .i_wdata(stab_wdata),
        .i_raddr(r_cnt), .o_rdata(stab_rd)
    );

    rqst_ram #(.W(QEW), .D(rqst_pkg::QUEUES)) u_sq (
        .i_clk(i_clk), .i_we(sq_we), .i_waddr(r_assigned[QIW-1:0]),
        .i_wdata({r_entry, r_proc}), .i_raddr(r_cnt[QIW-1:0]), .o_rdata(sq_rd)
    );

    rqst_ram #(.W(QIW), .D(rqst_pkg::ENTRIES)) u_atab (
        .i_clk(i_clk), .i_we(atab_we), .i_waddr(r_cnt), .i_wdata(stab_rd),
        .i_raddr(r_addr), .o_rdata(atab_rd)
    );

    rqst_ram #(.W(QEW), .D(rqst_pkg::QUEUES)) u_aq (
        .i_clk(i_clk), .i_we(aq_we), .i_waddr(r_cnt[QIW-1:0]), .i_wdata(sq_rd),
        .i_raddr(aq_raddr), .o_rdata(aq_rd)
    );

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_ainit    = r_ainit;
        n_qvalid   = r_qvalid;
        n_assigned = r_assigned;
        n_failed   = r_failed;
        n_entry    = r_entry;
        n_proc     = r_proc;
        n_cur      = r_cur;
        n_scan     = r_scan;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_q        = r_q;
        n_rdy      = out_load ? 1'b0 : r_rdy;
        n_rq       = r_rq;
        n_rp       = r_rp;
        n_rf       = r_rf;
        n_ra       = r_ra;
        n_rs       = r_rs;
        stab_we    = 1'b0;
        stab_wdata = r_cnt[QIW-1:0];
        sq_we      = 1'b0;
        atab_we    = 1'b0;
        aq_we      = 1'b0;
        aq_raddr   = r_q;

        case (r_state)
            rqst_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_rq = '0;
                    n_rp = '0;
                    n_rf = '0;
                    n_ra = '0;
                    n_rs = rqst_pkg::ST_OK;
                    case (i_s_tuser)
                        rqst_pkg::OP_LOAD: begin
                            n_entry    = i_s_tdata[6:0];
                            n_proc     = i_s_tdata[12:7];
                            n_failed   = eff_failed;
                            n_assigned = eff_assigned;
                            n_cnt      = '0;
                            if (eff_failed) begin
                                n_ra  = eff_assigned;
                                n_rs  = rqst_pkg::ST_FAIL;
                                n_rdy = 1'b1;
                            end else begin
                                n_state = rqst_pkg::S_LRD;
                            end
                        end
                        rqst_pkg::OP_COMMIT: begin
                            n_ra  = r_assigned;
                            n_cnt = '0;
                            if (r_failed || r_assigned == '0) begin
                                n_rs  = rqst_pkg::ST_FAIL;
                                n_rdy = 1'b1;
                            end else if (r_assigned > r_qcount) begin
                                n_rs  = rqst_pkg::ST_REJECT;
                                n_rdy = 1'b1;
                            end else begin
                                n_state = rqst_pkg::S_CRD;
                            end
                        end
                        rqst_pkg::OP_LOOKUP: begin
                            n_cur  = i_s_tdata[50:45];
                            n_scan = (in_hash == '0) && (r_mask != '0) && !i_s_tdata[51];
                            n_addr = n_scan ? '0 : (in_hash[EIW-1:0] & r_mask);
                            n_state = rqst_pkg::S_TRD;
                        end
                        default: begin
                            n_rdy = 1'b1;
                        end
                    endcase
                end
            end
            rqst_pkg::S_LRD: begin
                if ({1'b0, r_cnt[QIW-1:0]} == r_assigned || r_cnt[QIW]) begin
                    // No staged queue has this processor: open a new one, or fail if all are in use.
                    if (r_assigned[QIW]) begin
                        n_failed = 1'b1;
                        n_ra     = r_assigned;
                        n_rs     = rqst_pkg::ST_FAIL;
                    end else begin
                        sq_we      = 1'b1;
                        stab_we    = 1'b1;
                        stab_wdata = r_assigned[QIW-1:0];
                        n_assigned = r_assigned + 1'b1;
                        n_rq = r_assigned[QIW-1:0];
                        n_rp = r_proc;
                        n_rf = r_entry;
                        n_ra = r_assigned + 1'b1;
                        n_rs = rqst_pkg::ST_OK;
                    end
                    n_rdy   = 1'b1;
                    n_state = rqst_pkg::S_IDLE;
                end else begin
                    n_state = rqst_pkg::S_LCMP;
                end
            end
            rqst_pkg::S_LCMP: begin
                if (sq_rd[PW-1:0] == r_proc) begin
                    stab_we    = 1'b1;
                    stab_wdata = r_cnt[QIW-1:0];
                    n_rq = r_cnt[QIW-1:0];
                    n_rp = sq_rd[PW-1:0];
                    n_rf = sq_rd[QEW-1:PW];
                    n_ra = r_assigned;
                    n_rs = rqst_pkg::ST_OK;
                    n_rdy   = 1'b1;
                    n_state = rqst_pkg::S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = rqst_pkg::S_LRD;
                end
            end
            rqst_pkg::S_CRD: begin
                n_state = rqst_pkg::S_CWR;
            end
            rqst_pkg::S_CWR: begin
                atab_we = 1'b1;
                if ({1'b0, r_cnt} < {{(EIW-QIW){1'b0}}, r_assigned}) begin
                    aq_we = 1'b1;
                    n_qvalid[r_cnt[QIW-1:0]] = 1'b1;
                end
                if (r_cnt == EIW'(rqst_pkg::ENTRIES - 1)) begin
                    n_mask  = EIW'((8'd1 << r_tsl2) - 8'd1);
                    n_ainit = 1'b1;
                    n_rdy   = 1'b1;
                    n_state = rqst_pkg::S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = rqst_pkg::S_CRD;
                end
            end
            rqst_pkg::S_TRD: begin
                n_state = rqst_pkg::S_QRD;
            end
            rqst_pkg::S_QRD: begin
                aq_raddr = tab_q;
                n_q      = tab_q;
                n_state  = rqst_pkg::S_EVAL;
            end
            rqst_pkg::S_FB: begin
                // No entry matched the current processor: use queue 0.
                aq_raddr = '0;
                n_q      = '0;
                n_scan   = 1'b0;
                n_state  = rqst_pkg::S_EVAL;
            end
            rqst_pkg::S_EVAL: begin
                if (!r_scan || ev_proc == r_cur) begin
                    n_rq = r_q;
                    n_rp = ev_proc;
                    n_rf = ev_first;
                    n_ra = '0;
                    n_rs = rqst_pkg::ST_OK;
                    n_rdy   = 1'b1;
                    n_state = rqst_pkg::S_IDLE;
                end else if (r_addr == r_mask) begin
                    n_state = rqst_pkg::S_FB;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = rqst_pkg::S_TRD;
                end
            end
            default: begin
                n_state = rqst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rqst_pkg::S_IDLE;
            r_qcount   <= 7'd1;
            r_tsl2     <= '0;
            r_mask     <= '0;
            r_ainit    <= 1'b0;
            r_qvalid   <= '0;
            r_assigned <= '0;
            r_failed   <= 1'b0;
            r_rdy      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mask     <= n_mask;
            r_ainit    <= n_ainit;
            r_qvalid   <= n_qvalid;
            r_assigned <= n_assigned;
            r_failed   <= n_failed;
            r_rdy      <= n_rdy;
            if (i_cfg_valid) begin
                if (i_cfg_index == rqst_pkg::REG_QUEUE_COUNT) begin
                    r_qcount <= i_cfg_data;
                end else begin
                    r_tsl2 <= i_cfg_data[2:0];
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_proc  <= n_proc;
        r_cur   <= n_cur;
        r_scan  <= n_scan;
        r_addr  <= n_addr;
        r_cnt   <= n_cnt;
        r_q     <= n_q;
        r_rq    <= n_rq;
        r_rp    <= n_rp;
        r_rf    <= n_rf;
        r_ra    <= n_ra;
        r_rs    <= n_rs;
        if (out_load) begin
            r_odata <= {r_ra, r_rf, r_rp, r_rq};
            r_ostat <= r_rs;
        end
    end

    assign o_m_tdata  = {6'd0, r_odata};
    assign o_m_tuser  = r_ostat;
    assign o_m_tvalid = r_ovalid;

endmodule
